[src/d8fd_pkg.sv]
// Shared types and constants for the D8 flow direction block.
// Holds direction codes, scan orders, register indexes and the result word layout.
// No dependencies.
package d8fd_pkg;

	typedef logic [3:0] code_t;

	localparam code_t CODE_PIT        = 4'd0;
	localparam code_t CODE_UP         = 4'd1;
	localparam code_t CODE_UP_RIGHT   = 4'd2;
	localparam code_t CODE_RIGHT      = 4'd3;
	localparam code_t CODE_DOWN_RIGHT = 4'd4;
	localparam code_t CODE_DOWN       = 4'd5;
	localparam code_t CODE_DOWN_LEFT  = 4'd6;
	localparam code_t CODE_LEFT       = 4'd7;
	localparam code_t CODE_UP_LEFT    = 4'd8;
	localparam code_t CODE_NODATA     = 4'd9;

	// slot 0 in the lowest nibble
	localparam logic [7:0][3:0] SCAN_MAIN = {CODE_UP_LEFT, CODE_LEFT, CODE_DOWN_LEFT,
		CODE_DOWN, CODE_DOWN_RIGHT, CODE_RIGHT, CODE_UP_RIGHT, CODE_UP};
	localparam logic [7:0][3:0] SCAN_EDGE = {CODE_PIT, CODE_PIT, CODE_PIT,
		CODE_UP, CODE_UP_LEFT, CODE_LEFT, CODE_DOWN_LEFT, CODE_DOWN};

	localparam logic [7:0] MASK_ALL  = 8'hFF;
	localparam logic [7:0] MASK_FIVE = 8'h1F;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_GRID_COLUMNS   = 2'd0;
	localparam reg_idx_t REG_GRID_ROWS      = 2'd1;
	localparam reg_idx_t REG_MISSING_MARKER = 2'd2;

	localparam int GRID_COLUMNS_W = 11;
	localparam int GRID_ROWS_W    = 16;
	localparam int MARKER_W       = 32;

	localparam logic [GRID_COLUMNS_W-1:0] GRID_COLUMNS_RST   = 11'd1024;
	localparam logic [GRID_ROWS_W-1:0]    GRID_ROWS_RST      = 16'd1024;
	localparam logic [MARKER_W-1:0]       MISSING_MARKER_RST = 32'hFFD8_F100;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;

	typedef struct packed {
		logic  frame_done;
		logic  row_done;
		code_t flow_code;
	} result_t;

endpackage

[src/d8fd_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module d8fd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/d8fd_descent.sv]
// Lowest-neighbor descent pick over up to eight neighbors, earliest slot wins a tie.
// Depends on d8fd_pkg for the code type.
module d8fd_descent import d8fd_pkg::*; #(
	parameter int EB = 32
) (
	input  logic signed [EB-1:0] marker,
	input  logic signed [EB-1:0] center,
	input  logic [7:0][EB-1:0]   nb,
	input  logic [7:0]           en,
	input  logic [7:0][3:0]      codes,
	output code_t                code
);

	logic signed [EB-1:0] l1_val [4];
	logic                 l1_ok  [4];
	code_t                l1_cd  [4];
	logic signed [EB-1:0] l2_val [2];
	logic                 l2_ok  [2];
	code_t                l2_cd  [2];
	logic signed [EB-1:0] best_val;
	logic                 best_ok;
	code_t                best_cd;
	logic                 leaf_ok [8];

	function automatic logic take_right(input logic l_ok, input logic signed [EB-1:0] l_val,
		input logic r_ok, input logic signed [EB-1:0] r_val);
		return r_ok && (!l_ok || (r_val < l_val));
	endfunction

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			leaf_ok[i] = en[i] && ($signed(nb[i]) != marker);
		end
		for (int i = 0; i < 4; i++) begin
			if (take_right(leaf_ok[2*i], $signed(nb[2*i]), leaf_ok[2*i+1],
				$signed(nb[2*i+1]))) begin
				l1_val[i] = $signed(nb[2*i+1]);
				l1_ok[i]  = 1'b1;
				l1_cd[i]  = codes[2*i+1];
			end else begin
				l1_val[i] = $signed(nb[2*i]);
				l1_ok[i]  = leaf_ok[2*i];
				l1_cd[i]  = codes[2*i];
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (take_right(l1_ok[2*i], l1_val[2*i], l1_ok[2*i+1], l1_val[2*i+1])) begin
				l2_val[i] = l1_val[2*i+1];
				l2_ok[i]  = 1'b1;
				l2_cd[i]  = l1_cd[2*i+1];
			end else begin
				l2_val[i] = l1_val[2*i];
				l2_ok[i]  = l1_ok[2*i];
				l2_cd[i]  = l1_cd[2*i];
			end
		end
		if (take_right(l2_ok[0], l2_val[0], l2_ok[1], l2_val[1])) begin
			best_val = l2_val[1];
			best_ok  = 1'b1;
			best_cd  = l2_cd[1];
		end else begin
			best_val = l2_val[0];
			best_ok  = l2_ok[0];
			best_cd  = l2_cd[0];
		end
		if (center == marker) begin
			code = CODE_NODATA;
		end else if (best_ok && (best_val < center)) begin
			code = best_cd;
		end else begin
			code = CODE_PIT;
		end
	end

endmodule

[src/d8_flow_direction_top.sv]
// Top level of the D8 flow direction block: line buffers, window, result queue.
// Depends on d8fd_pkg, d8fd_ram and d8fd_descent.
//
// Usage:
//   s_* carries elevation words in raster order, one cell per word. After the
//   real rows the host sends one extra row of no-data cells so the last row
//   is emitted. m_* returns one direction word per grid cell, row r-1 while
//   input row r streams in; tlast marks the last column of a row, tuser the
//   final cell of the grid. cfg_* writes grid_columns (0), grid_rows (1) and
//   missing_marker (2); write only while the block is idle.
//   Path: an accepted word passes the input-stage (_s1) and window-stage
//   (_s2) registers, and its result is pushed into the queue that drives m_*.
//   Throughput: one input word per cycle while s_tready is high. Each word
//   reads and writes each of two line-buffer RAMs once; a read and a write
//   in the same cycle hit distinct addresses, so no interlock is needed. A
//   row end causes two results; a 16-entry result queue absorbs them and
//   s_tready drops only when it cannot hold the worst case of words in flight.
//   Reset clears the row and column position and the queue and loads the
//   register defaults; line-buffer contents stay undefined until written.
//   When m_tready is low the queue fills and s_tready then falls.
module d8_flow_direction_top import d8fd_pkg::*; #(
	parameter int MAX_COLUMNS    = 1024,
	parameter int ELEVATION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] elevation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] flow_code, [7:4] zero
	output logic        m_tlast,   // row_done
	output logic        m_tuser,   // [0] frame_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int EB = ELEVATION_BITS;
	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int XW = (CW > GRID_COLUMNS_W) ? CW : GRID_COLUMNS_W;

	typedef logic signed [EB-1:0] elev_t;

	logic [GRID_COLUMNS_W-1:0] grid_columns_q;
	logic [GRID_ROWS_W-1:0]    grid_rows_q;
	logic [MARKER_W-1:0]       marker_q;
	elev_t                     marker;

	logic [AW-1:0]          col_q;
	logic [GRID_ROWS_W-1:0] row_q;

	logic          accept;
	logic [XW-1:0] cols_x;
	logic [XW-1:0] cols_eff;
	logic [XW-1:0] last_x;
	logic [AW-1:0] last_col;
	logic [AW-1:0] c_eff;
	logic          is_last;
	logic          last_row;

	logic          v1_s1;
	logic [AW-1:0] c_s1;
	elev_t         low_s1;
	logic          row1_s1;
	logic          main_s1;
	logic          left_s1;
	logic          right_s1;
	logic          frame_s1;

	logic [EB-1:0] up_rd;
	logic [EB-1:0] mid_rd;
	elev_t         up;
	elev_t         mid;
	elev_t         win_a_q [3];
	elev_t         win_b_q [3];

	logic               v2_s2;
	logic               main_s2;
	logic               right_s2;
	logic               frame_s2;
	elev_t              ctr_main_s2;
	elev_t              ctr_edge_s2;
	logic [7:0][EB-1:0] nb_main_s2;
	logic [7:0][EB-1:0] nb_edge_s2;
	logic [7:0]         en_main_s2;
	code_t              code_main;
	code_t              code_edge;

	result_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q;
	logic [FIFO_AW-1:0]   rp_q;
	logic [FIFO_AW:0]     cnt_q;
	logic [FIFO_AW+1:0]   need;
	logic [1:0]           push_n;
	logic                 pop;
	result_t              res_main;
	result_t              res_edge;
	result_t              head;

	assign cfg_ready = 1'b1;
	assign marker    = marker_q[EB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_COLUMNS_RST;
			grid_rows_q    <= GRID_ROWS_RST;
			marker_q       <= MISSING_MARKER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GRID_COLUMNS:   grid_columns_q <= cfg_data[GRID_COLUMNS_W-1:0];
				REG_GRID_ROWS:      grid_rows_q    <= cfg_data[GRID_ROWS_W-1:0];
				REG_MISSING_MARKER: marker_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage: position, clamping, RAM read
	assign need     = {1'b0, cnt_q} + {{FIFO_AW{1'b0}}, v1_s1, 1'b0}
		+ {{FIFO_AW{1'b0}}, v2_s2, 1'b0} + (FIFO_AW+2)'(2);
	assign s_tready = need <= (FIFO_AW+2)'(FIFO_DEPTH);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cols_x = XW'(grid_columns_q);
		if (cols_x < XW'(3)) begin
			cols_eff = XW'(3);
		end else if (cols_x > XW'(MAX_COLUMNS)) begin
			cols_eff = XW'(MAX_COLUMNS);
		end else begin
			cols_eff = cols_x;
		end
		last_x   = cols_eff - XW'(1);
		last_col = last_x[AW-1:0];
		c_eff    = (XW'(col_q) > last_x) ? last_col : col_q;
		is_last  = c_eff == last_col;
		last_row = row_q >= grid_rows_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v1_s1 <= 1'b0;
		end else begin
			v1_s1 <= accept;
			if (accept) begin
				if (is_last) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + GRID_ROWS_W'(1);
				end else begin
					col_q <= c_eff + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1     <= c_eff;
			low_s1   <= s_tdata[EB-1:0];
			row1_s1  <= row_q == GRID_ROWS_W'(1);
			main_s1  <= (row_q != '0) && (c_eff != '0);
			left_s1  <= c_eff == AW'(1);
			right_s1 <= (row_q != '0) && is_last;
			frame_s1 <= last_row;
		end
	end

	d8fd_ram #(.WIDTH(EB), .DEPTH(MAX_COLUMNS)) u_ram_upper (
		.clk     (clk),
		.wr_en   (v1_s1),
		.wr_addr (c_s1),
		.wr_data (mid_rd),
		.rd_en   (accept),
		.rd_addr (c_eff),
		.rd_data (up_rd)
	);

	d8fd_ram #(.WIDTH(EB), .DEPTH(MAX_COLUMNS)) u_ram_middle (
		.clk     (clk),
		.wr_en   (v1_s1),
		.wr_addr (c_s1),
		.wr_data (low_s1),
		.rd_en   (accept),
		.rd_addr (c_eff),
		.rd_data (mid_rd)
	);

	// window stage: gather neighbors, shift window
	assign mid = mid_rd;
	assign up  = row1_s1 ? marker : elev_t'(up_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v1_s1) begin
			main_s2     <= main_s1;
			right_s2    <= right_s1;
			frame_s2    <= frame_s1;
			en_main_s2  <= left_s1 ? MASK_FIVE : MASK_ALL;
			ctr_main_s2 <= win_b_q[1];
			nb_main_s2  <= {win_a_q[0], win_a_q[1], win_a_q[2], win_b_q[2],
				low_s1, mid, up, win_b_q[0]};
			ctr_edge_s2 <= mid;
			nb_edge_s2  <= {{(3*EB){1'b0}}, up, win_b_q[0], win_b_q[1], win_b_q[2], low_s1};
			for (int i = 0; i < 3; i++) begin
				win_a_q[i] <= win_b_q[i];
			end
			win_b_q[0] <= up;
			win_b_q[1] <= mid;
			win_b_q[2] <= low_s1;
		end
	end

	// decision stage
	d8fd_descent #(.EB(EB)) u_descent_main (
		.marker (marker),
		.center (ctr_main_s2),
		.nb     (nb_main_s2),
		.en     (en_main_s2),
		.codes  (SCAN_MAIN),
		.code   (code_main)
	);

	d8fd_descent #(.EB(EB)) u_descent_edge (
		.marker (marker),
		.center (ctr_edge_s2),
		.nb     (nb_edge_s2),
		.en     (MASK_FIVE),
		.codes  (SCAN_EDGE),
		.code   (code_edge)
	);

	// result queue
	assign res_main = '{frame_done: 1'b0, row_done: 1'b0, flow_code: code_main};
	assign res_edge = '{frame_done: frame_s2, row_done: 1'b1, flow_code: code_edge};
	assign push_n   = v2_s2 ? ({1'b0, main_s2} + {1'b0, right_s2}) : 2'd0;
	assign head     = fifo_q[rp_q];
	assign m_tvalid = cnt_q != '0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = {4'b0000, head.flow_code};
	assign m_tlast  = head.row_done;
	assign m_tuser  = head.frame_done;

	always_ff @(posedge clk) begin
		if (v2_s2) begin
			if (main_s2) begin
				fifo_q[wp_q] <= res_main;
				if (right_s2) begin
					fifo_q[wp_q + FIFO_AW'(1)] <= res_edge;
				end
			end else if (right_s2) begin
				fifo_q[wp_q] <= res_edge;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(push_n);
			rp_q  <= rp_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 |-> ((FIFO_AW+2)'(cnt_q) + (FIFO_AW+2)'(push_n) <= (FIFO_AW+2)'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_frame_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("frame end without row end");

	a_ram_addr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && v1_s1) |-> (c_eff != c_s1))
		else $error("line buffer read and write hit the same entry");

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 v2_s2)
		else $error("word lost between stages");

endmodule

[verif/d8fd_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the D8 flow direction block: an own model of the line
// buffers and window that predicts direction words, and the compare against them.
// Depends on d8fd_pkg for the register indexes, direction codes and result layout.
package d8fd_tb_pkg;

	import d8fd_pkg::*;

	localparam int LINE_DEPTH = 1024;

	typedef logic signed [31:0] elev_t;
	typedef enum int {SCAN_FULL, SCAN_LEFT_COL, SCAN_RIGHT_COL} scan_e;

	class flow_board;
		logic [GRID_COLUMNS_W-1:0] columns;
		logic [GRID_ROWS_W-1:0]    rows;
		elev_t                     marker;
		elev_t                     upper_line[LINE_DEPTH];
		elev_t                     middle_line[LINE_DEPTH];
		elev_t                     window[6];
		int                        col_pos;
		int                        row_pos;
		result_t                   due_codes[$];
		int                        errors;

		function new();
			columns = GRID_COLUMNS_RST;
			rows    = GRID_ROWS_RST;
			marker  = MISSING_MARKER_RST;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors  = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_GRID_COLUMNS:   columns = value[GRID_COLUMNS_W-1:0];
				REG_GRID_ROWS:      rows = value[GRID_ROWS_W-1:0];
				REG_MISSING_MARKER: marker = value;
				default: ;
			endcase
		endfunction

		function code_t scan_code(scan_e kind, int slot);
			if (kind == SCAN_RIGHT_COL) begin
				case (slot)
					0: return CODE_DOWN;
					1: return CODE_DOWN_LEFT;
					2: return CODE_LEFT;
					3: return CODE_UP_LEFT;
					default: return CODE_UP;
				endcase
			end
			case (slot)
				0: return CODE_UP;
				1: return CODE_UP_RIGHT;
				2: return CODE_RIGHT;
				3: return CODE_DOWN_RIGHT;
				4: return CODE_DOWN;
				5: return CODE_DOWN_LEFT;
				6: return CODE_LEFT;
				default: return CODE_UP_LEFT;
			endcase
		endfunction

		function code_t descend(elev_t center, elev_t nb[8], scan_e kind);
			elev_t lowest;
			code_t code;
			int    count;
			if (center == marker) return CODE_NODATA;
			lowest = center;
			code   = CODE_PIT;
			count  = (kind == SCAN_FULL) ? 8 : 5;
			for (int i = 0; i < count; i++) begin
				if (nb[i] != marker && nb[i] < lowest) begin
					lowest = nb[i];
					code   = scan_code(kind, i);
				end
			end
			return code;
		endfunction

		function void push_code(code_t code, logic row_end, logic frame_end);
			result_t r;
			r.flow_code  = code;
			r.row_done   = row_end;
			r.frame_done = frame_end;
			due_codes.push_back(r);
		endfunction

		function void take_elevation(elev_t low);
			int    width;
			int    c;
			elev_t up;
			elev_t mid;
			elev_t nb[8];
			logic  last_row;
			width    = (columns < 3) ? 3 : (columns > LINE_DEPTH) ? LINE_DEPTH : int'(columns);
			c        = (col_pos > width - 1) ? width - 1 : col_pos;
			last_row = (row_pos >= rows);
			mid = middle_line[c];
			up  = (row_pos == 1) ? marker : upper_line[c];
			upper_line[c]  = mid;
			middle_line[c] = low;
			if (row_pos >= 1) begin
				if (c == 1) begin
					nb = '{window[3], up, mid, low, window[5], marker, marker, marker};
					push_code(descend(window[4], nb, SCAN_LEFT_COL), 1'b0, 1'b0);
				end else if (c >= 2) begin
					nb = '{window[3], up, mid, low, window[5], window[2], window[1], window[0]};
					push_code(descend(window[4], nb, SCAN_FULL), 1'b0, 1'b0);
				end
				if (c == width - 1) begin
					nb = '{low, window[5], window[4], window[3], up, marker, marker, marker};
					push_code(descend(mid, nb, SCAN_RIGHT_COL), 1'b1, last_row);
				end
			end
			window[0] = window[3];
			window[1] = window[4];
			window[2] = window[5];
			window[3] = up;
			window[4] = mid;
			window[5] = low;
			if (c >= width - 1) begin
				col_pos = 0;
				row_pos = last_row ? 0 : row_pos + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		task flag_mismatch(string msg);
			errors++;
			if (errors <= 40) $display("ERROR %s", msg);
		endtask

		task match_code(result_t got);
			result_t want;
			if (due_codes.size() == 0) begin
				flag_mismatch($sformatf("unexpected word: code %0d row_done %0b frame_done %0b",
					got.flow_code, got.row_done, got.frame_done));
				return;
			end
			want = due_codes.pop_front();
			if (got.flow_code !== want.flow_code)
				flag_mismatch($sformatf("flow_code %0d, want %0d", got.flow_code, want.flow_code));
			if (got.row_done !== want.row_done)
				flag_mismatch($sformatf("row_done %0b, want %0b", got.row_done, want.row_done));
			if (got.frame_done !== want.frame_done)
				flag_mismatch($sformatf("frame_done %0b, want %0b", got.frame_done,
					want.frame_done));
		endtask

		task close_out();
			if (due_codes.size() != 0)
				flag_mismatch($sformatf("%0d words never arrived", due_codes.size()));
		endtask
	endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Top of the D8 flow direction testbench: clock, reset, stream and register drivers.
// Runs directed grids, then random grids, then further directed grids, all under random gaps and stalls.
// Depends on d8fd_pkg, d8fd_tb_pkg and d8_flow_direction_top.
module tb_top;

	import d8fd_pkg::*;
	import d8fd_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_WORDS = 580;

	typedef enum int {STYLE_ROUGH, STYLE_FULL, STYLE_EDGE} style_e;
	typedef enum int {RX_OPEN, RX_COIN, RX_TOGGLE, RX_CHOKE} rx_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	flow_board board = new();

	elev_t       word_queue[$];
	elev_t       cur_marker = MISSING_MARKER_RST;
	int          rough_base = 0;
	int          burst_left = 0;
	int          cycles     = 0;
	rx_e         rx_mode    = RX_OPEN;
	int          rx_left    = 0;
	logic [15:0] rx_phase   = '0;

	d8_flow_direction_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL d8_flow_direction_top");
			$finish;
		end
	end

	always @(negedge clk) begin
		rx_phase <= rx_phase + 16'd1;
		if (rx_left == 0) begin
			rx_mode <= rx_e'($urandom_range(0, 3));
			rx_left <= $urandom_range(64, 256);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_TOGGLE: m_tready <= rx_phase[3];
			default:   m_tready <= ($urandom_range(0, 9) < 2);
		endcase
	end

	always @(posedge clk) begin : watch_results
		result_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen.flow_code  = m_tdata[3:0];
			seen.row_done   = m_tlast;
			seen.frame_done = m_tuser;
			board.match_code(seen);
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_grid(int cols, int rows, elev_t marker);
		write_reg(REG_GRID_COLUMNS, cols);
		write_reg(REG_GRID_ROWS, rows);
		write_reg(REG_MISSING_MARKER, marker);
		cur_marker = marker;
	endtask

	task automatic stream_words();
		elev_t w;
		int    gap;
		int    r;
		while (word_queue.size() != 0) begin
			if (burst_left == 0) begin
				r   = $urandom_range(0, 99);
				gap = (r < 35) ? 0 : (r < 90) ? $urandom_range(1, 6) : $urandom_range(12, 40);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 48);
			end
			w = word_queue.pop_front();
			s_tvalid <= 1'b1;
			s_tdata  <= w;
			do @(posedge clk); while (!s_tready);
			board.take_elevation(w);
			@(negedge clk);
			burst_left--;
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (board.due_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic elev_t pick_elev(style_e style, int hole_pct);
		if ($urandom_range(0, 99) < hole_pct) return cur_marker;
		case (style)
			STYLE_FULL: return $urandom;
			STYLE_EDGE: begin
				case ($urandom_range(0, 7))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 0;
					3: return cur_marker + 1;
					4: return cur_marker - 1;
					5: return -1;
					6: return 1;
					default: return cur_marker;
				endcase
			end
			default: return rough_base + $signed($urandom_range(0, 12)) - 6;
		endcase
	endfunction

	// the row after the real rows is mostly no-data, sometimes live values
	task automatic drive_grid(int width, int rows, style_e style, int hole_pct);
		word_queue.delete();
		rough_base = $signed($urandom) >>> 2;
		for (int r = 0; r <= rows; r++) begin
			for (int c = 0; c < width; c++) begin
				if (r == rows && $urandom_range(0, 4) != 0)
					word_queue.push_back(cur_marker);
				else
					word_queue.push_back(pick_elev(style, hole_pct));
			end
		end
		stream_words();
	endtask

	initial begin
		int     random_words;
		int     cols;
		int     width;
		int     rows;
		int     r;
		elev_t  marker;
		style_e style;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_grid(3, 2, MISSING_MARKER_RST);
		word_queue = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0,
			MISSING_MARKER_RST, 5, 5,
			MISSING_MARKER_RST, MISSING_MARKER_RST, MISSING_MARKER_RST};
		stream_words();
		wait_idle();

		set_grid(3, 3, 32'sh8000_0000);
		word_queue = '{10, 10, 10,
			10, 20, 10,
			30, 10, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		stream_words();
		wait_idle();

		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			cols  = (r < 5) ? $urandom_range(0, 2) :
				(r < 75) ? $urandom_range(3, 10) : $urandom_range(11, 48);
			width = (cols < 3) ? 3 : cols;
			rows  = $urandom_range(1, 6);
			r = $urandom_range(0, 99);
			marker = (r < 40) ? cur_marker : (r < 55) ? elev_t'(MISSING_MARKER_RST) :
				(r < 65) ? 32'sh8000_0000 : (r < 75) ? 32'sh7FFF_FFFF :
				(r < 85) ? 0 : elev_t'($urandom);
			r = $urandom_range(0, 99);
			style = (r < 60) ? STYLE_ROUGH : (r < 80) ? STYLE_FULL : STYLE_EDGE;
			set_grid(cols, rows, marker);
			drive_grid(width, rows, style, $urandom_range(0, 30));
			random_words += width * (rows + 1);
			wait_idle();
		end

		set_grid(64, 2, MISSING_MARKER_RST);
		drive_grid(64, 2, STYLE_ROUGH, 10);
		wait_idle();

		set_grid(4, 0, cur_marker);
		drive_grid(4, 2, STYLE_ROUGH, 10);
		wait_idle();

		set_grid(3, 16'hFFFF, $urandom);
		drive_grid(3, 14, STYLE_FULL, 15);
		wait_idle();

		board.close_out();
		if (board.errors == 0)
			$display("PASS d8_flow_direction_top");
		else
			$display("FAIL d8_flow_direction_top");
		$finish;
	end

endmodule

[sim.f]
src/d8fd_pkg.sv
src/d8fd_ram.sv
src/d8fd_descent.sv
src/d8_flow_direction_top.sv
verif/d8fd_tb_pkg.sv
verif/tb_top.sv
